// ----- hw/rtl/scale_and_quaternion_rotate_point_assert.svh -----
// Assertion macros shared by the checker of the point rotation block.
// Depends on nothing; included by the checker file only.
`ifndef SCALE_AND_QUATERNION_ROTATE_POINT_ASSERT_SVH
`define SCALE_AND_QUATERNION_ROTATE_POINT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SQR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SQR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sqr_pkg.sv -----
// Shared types, widths and register codes for the scale and quaternion rotate block.
// Depends on nothing; imported by the top level, its checker and the test files.
`default_nettype none

package sqr_pkg;

  localparam int GRID_DIM  = 1024;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 64;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam int QUAT_W    = 16;
  localparam int SCALE_W   = 16;
  localparam int DIM_W     = 11;
  localparam int IDX_W     = 10;
  localparam int HGT_W     = 12;

  localparam int QPROD_W   = 32;
  localparam int COEF_W    = 34;
  localparam int P_W       = 29;
  localparam int PROD_W    = 63;
  localparam int SUM_W     = 64;
  localparam int FRAC_BITS = 37;
  localparam int Q_W       = SUM_W - FRAC_BITS;
  localparam int OUT_W     = 21;

  localparam int OUT_MAX   = 1048575;
  localparam int OUT_MIN   = -1048576;

  localparam logic [2:0] REG_QUAT_W   = 3'd0;
  localparam logic [2:0] REG_QUAT_X   = 3'd1;
  localparam logic [2:0] REG_QUAT_Y   = 3'd2;
  localparam logic [2:0] REG_QUAT_Z   = 3'd3;
  localparam logic [2:0] REG_SCALE    = 3'd4;
  localparam logic [2:0] REG_GRID_W   = 3'd5;
  localparam logic [2:0] REG_GRID_H   = 3'd6;

  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [QPROD_W-1:0] qprod_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [P_W-1:0]     point_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   acc_t;
  typedef logic signed [OUT_W-1:0]   coord_t;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(OUT_MAX);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(OUT_MIN);
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);

  // Floor the rounded sum to an integer and clamp to the output range.
  function automatic coord_t sat_coord(acc_t v);
    logic signed [Q_W-1:0] q;
    coord_t r;
    q = v[SUM_W-1:FRAC_BITS];
    priority if (q > Q_MAX) begin
      r = coord_t'(OUT_MAX);
    end else if (q < Q_MIN) begin
      r = coord_t'(OUT_MIN);
    end else begin
      r = coord_t'(q);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scale_and_quaternion_rotate_point.sv -----
// Scale-and-rotate point transform: top level with register port and pipeline.
// Depends on sqr_pkg.
//
// Usage:
//   Input stream s_*: one map point per transfer; s_tdata holds col, row, height.
//   Output stream m_*: one rotated point per input; m_tdata holds out_x, out_y, out_z.
//   Register port: APB-style, registers at byte address 4*i, writes take effect at
//   the access cycle; write them while no point is in flight.
//   Throughput: one point per cycle; a new point is taken every cycle the path
//   ahead can move, so up to five points are held in the stages at once.
//   Steps from an input transfer to m_tvalid: input register, scale multiply, nine
//   coefficient multiplies, sum and round, saturate into the output register.
//   Coefficients derive from the quaternion registers through two register stages.
//   Reset: clears all valid bits and loads the register defaults (identity
//   rotation, unit scale, 1x1 grid).
//   Stall: when m_tready is low each stage holds once the one ahead of it is
//   full; s_tready falls only when every stage is occupied.
`default_nettype none

module scale_and_quaternion_rotate_point
  import sqr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // APB-style register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic      [DATA_W-1:0]    prdata,
  output logic                      pready,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // col[9:0], row[19:10], height[31:20]
  // output stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata   // out_x[20:0], out_y[41:21], out_z[62:42], 0
);

  // configuration registers
  quat_t              quat_w, quat_x, quat_y, quat_z;
  logic [SCALE_W-1:0] scale_factor;
  logic [DIM_W-1:0]   grid_width, grid_height;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w       <= quat_t'(16384);
      quat_x       <= '0;
      quat_y       <= '0;
      quat_z       <= '0;
      scale_factor <= SCALE_W'(256);
      grid_width   <= DIM_W'(1);
      grid_height  <= DIM_W'(1);
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_QUAT_W: quat_w       <= pwdata[QUAT_W-1:0];
        REG_QUAT_X: quat_x       <= pwdata[QUAT_W-1:0];
        REG_QUAT_Y: quat_y       <= pwdata[QUAT_W-1:0];
        REG_QUAT_Z: quat_z       <= pwdata[QUAT_W-1:0];
        REG_SCALE:  scale_factor <= pwdata[SCALE_W-1:0];
        REG_GRID_W: grid_width   <= pwdata[DIM_W-1:0];
        REG_GRID_H: grid_height  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_QUAT_W: prdata = DATA_W'(quat_w);
      REG_QUAT_X: prdata = DATA_W'(quat_x);
      REG_QUAT_Y: prdata = DATA_W'(quat_y);
      REG_QUAT_Z: prdata = DATA_W'(quat_z);
      REG_SCALE:  prdata = DATA_W'(scale_factor);
      REG_GRID_W: prdata = DATA_W'(grid_width);
      REG_GRID_H: prdata = DATA_W'(grid_height);
      default:    prdata = '0;
    endcase
  end

  // rotation coefficients: products, then matrix entries
  qprod_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  coef_t  coef [3][3];

  always_ff @(posedge clk) begin
    ww <= quat_w * quat_w;
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
    xy <= quat_x * quat_y;
    xz <= quat_x * quat_z;
    yz <= quat_y * quat_z;
    wx <= quat_w * quat_x;
    wy <= quat_w * quat_y;
    wz <= quat_w * quat_z;
  end

  always_ff @(posedge clk) begin
    coef[0][0] <= coef_t'(ww) + coef_t'(xx) - coef_t'(yy) - coef_t'(zz);
    coef[0][1] <= (coef_t'(xy) - coef_t'(wz)) <<< 1;
    coef[0][2] <= (coef_t'(xz) + coef_t'(wy)) <<< 1;
    coef[1][0] <= (coef_t'(xy) + coef_t'(wz)) <<< 1;
    coef[1][1] <= coef_t'(ww) - coef_t'(xx) + coef_t'(yy) - coef_t'(zz);
    coef[1][2] <= (coef_t'(yz) - coef_t'(wx)) <<< 1;
    coef[2][0] <= (coef_t'(xz) - coef_t'(wy)) <<< 1;
    coef[2][1] <= (coef_t'(yz) + coef_t'(wx)) <<< 1;
    coef[2][2] <= coef_t'(ww) - coef_t'(xx) - coef_t'(yy) + coef_t'(zz);
  end

  // stage enables
  logic v1, v2, v3, v4;
  logic ce1, ce2, ce3, ce4, ce_out;

  assign ce_out   = ~m_tvalid | m_tready;
  assign ce4      = ~v4 | ce_out;
  assign ce3      = ~v3 | ce4;
  assign ce2      = ~v2 | ce3;
  assign ce1      = ~v1 | ce2;
  assign s_tready = ce1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ce1)    v1       <= s_tvalid;
      if (ce2)    v2       <= v1;
      if (ce3)    v3       <= v2;
      if (ce4)    v4       <= v3;
      if (ce_out) m_tvalid <= v4;
    end
  end

  // stage 1: input register
  logic [IDX_W-1:0]        col1, row1;
  logic signed [HGT_W-1:0] hgt1;

  always_ff @(posedge clk) begin
    if (ce1 && s_tvalid) begin
      col1 <= s_tdata[IDX_W-1:0];
      row1 <= s_tdata[2*IDX_W-1:IDX_W];
      hgt1 <= s_tdata[2*IDX_W+HGT_W-1:2*IDX_W];
    end
  end

  // stage 2: scaled point, Q.9 so the half-grid offset stays exact
  logic [DIM_W-1:0]         gw_clamp, gh_clamp;
  logic [DIM_W:0]           xs, ys;
  logic [DIM_W+SCALE_W:0]   xm, ym;
  logic signed [HGT_W:0]    hs;
  logic signed [HGT_W+SCALE_W+1:0] zm;
  point_t                   pt [3];

  always_comb begin
    gw_clamp = (32'(grid_width)  > GRID_DIM) ? DIM_W'(GRID_DIM) : grid_width;
    gh_clamp = (32'(grid_height) > GRID_DIM) ? DIM_W'(GRID_DIM) : grid_height;
    xs = {col1, 1'b0} + {1'b0, gw_clamp};
    ys = {row1, 1'b0} + {1'b0, gh_clamp};
    xm = xs * scale_factor;
    ym = ys * scale_factor;
    hs = {hgt1, 1'b0};
    zm = hs * $signed({1'b0, scale_factor});
  end

  always_ff @(posedge clk) begin
    if (ce2 && v1) begin
      pt[0] <= point_t'(xm);
      pt[1] <= point_t'(ym);
      pt[2] <= point_t'(zm);
    end
  end

  // stage 3: coefficient products
  prod_t prod [3][3];

  always_ff @(posedge clk) begin
    if (ce3 && v2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= coef[i][j] * pt[j];
        end
      end
    end
  end

  // stage 4: row sums with the rounding half
  acc_t acc [3];

  always_ff @(posedge clk) begin
    if (ce4 && v3) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= acc_t'(prod[i][0]) + acc_t'(prod[i][1]) + acc_t'(prod[i][2]) + ROUND_HALF;
      end
    end
  end

  // output register
  coord_t out_x, out_y, out_z;

  always_ff @(posedge clk) begin
    if (ce_out && v4) begin
      out_x <= sat_coord(acc[0]);
      out_y <= sat_coord(acc[1]);
      out_z <= sat_coord(acc[2]);
    end
  end

  assign m_tdata = {1'b0, out_z, out_y, out_x};

endmodule

`default_nettype wire

// ----- hw/rtl/sqr_checker.sv -----
// Port-level checker for the scale and quaternion rotate block, with its bind.
// Depends on sqr_pkg and scale_and_quaternion_rotate_point_assert.svh.
`default_nettype none
`include "scale_and_quaternion_rotate_point_assert.svh"

module sqr_checker
  import sqr_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 psel,
  input wire logic                 penable,
  input wire logic                 pwrite,
  input wire logic [ADDR_W-1:0]    paddr,
  input wire logic [DATA_W-1:0]    pwdata,
  input wire logic [DATA_W-1:0]    prdata,
  input wire logic                 pready,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [S_TDATA_W-1:0] s_tdata,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  `SQR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output transfer changed")
  `SQR_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[M_TDATA_W-1] == 1'b0, "output pad bit set")
  `SQR_ASSERT_NOW(a_ready_empty, clk, rst, !m_tvalid, s_tready, "input stalled while output register empty")
  `SQR_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_tvalid, "output valid right after reset")
  `SQR_ASSERT_NEXT(a_latency, clk, rst, (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 1'b1, m_tvalid, "result missing four cycles after transfer")

endmodule

bind scale_and_quaternion_rotate_point sqr_checker u_sqr_checker (.*);

`default_nettype wire

// ----- test/scale_and_quaternion_rotate_point_checker.sv -----
// Checker for the scale and quaternion rotate point block: follows register writes,
// predicts each rotated point and compares it field by field with the output stream.
// Depends on sqr_pkg.
module scale_and_quaternion_rotate_point_checker
  import sqr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  input  logic                 pready,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // col[9:0], row[19:10], height[31:20]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,  // out_x[20:0], out_y[41:21], out_z[62:42], 0
  output int                   mismatches,
  output int                   in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point3_t;

  quat_t               rot_w;
  quat_t               rot_x;
  quat_t               rot_y;
  quat_t               rot_z;
  logic [SCALE_W-1:0]  zoom;
  logic [DIM_W-1:0]    cols;
  logic [DIM_W-1:0]    rows;
  point3_t             expected_points[$];

  function automatic coord_t round_to_coord(longint v);
    longint q;
    q = (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
    end
    return coord_t'(q);
  endfunction

  function automatic point3_t predict_point(logic [IDX_W-1:0] c, logic [IDX_W-1:0] r,
                                            logic signed [HGT_W-1:0] h);
    longint  s, gx, gy, px, py, pz, w, x, y, z;
    point3_t p;
    s = longint'(zoom);
    gx = longint'(cols);
    gy = longint'(rows);
    if (gx > GRID_DIM) gx = GRID_DIM;
    if (gy > GRID_DIM) gy = GRID_DIM;
    px = 2 * longint'(c) * s + gx * s;
    py = 2 * longint'(r) * s + gy * s;
    pz = 2 * longint'(h) * s;
    w = rot_w;
    x = rot_x;
    y = rot_y;
    z = rot_z;
    p.x = round_to_coord((w*w + x*x - y*y - z*z) * px + 2 * (x*y - w*z) * py
                         + 2 * (x*z + w*y) * pz);
    p.y = round_to_coord(2 * (x*y + w*z) * px + (w*w - x*x + y*y - z*z) * py
                         + 2 * (y*z - w*x) * pz);
    p.z = round_to_coord(2 * (x*z - w*y) * px + 2 * (y*z + w*x) * py
                         + (w*w - x*x - y*y + z*z) * pz);
    return p;
  endfunction

  task automatic report(string msg);
    if (mismatches < 100) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    point3_t got;
    point3_t want;
    if (rst) begin
      expected_points.delete();
      rot_w = 16'sd16384;
      rot_x = '0;
      rot_y = '0;
      rot_z = '0;
      zoom  = 16'd256;
      cols  = 11'd1;
      rows  = 11'd1;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_QUAT_W: rot_w = quat_t'(pwdata[QUAT_W-1:0]);
          REG_QUAT_X: rot_x = quat_t'(pwdata[QUAT_W-1:0]);
          REG_QUAT_Y: rot_y = quat_t'(pwdata[QUAT_W-1:0]);
          REG_QUAT_Z: rot_z = quat_t'(pwdata[QUAT_W-1:0]);
          REG_SCALE:  zoom  = pwdata[SCALE_W-1:0];
          REG_GRID_W: cols  = pwdata[DIM_W-1:0];
          REG_GRID_H: rows  = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.x = coord_t'(m_tdata[OUT_W-1:0]);
        got.y = coord_t'(m_tdata[2*OUT_W-1:OUT_W]);
        got.z = coord_t'(m_tdata[3*OUT_W-1:2*OUT_W]);
        if (m_tdata[M_TDATA_W-1:3*OUT_W] != '0) report("m_tdata pad bits not zero");
        if (expected_points.size() == 0) begin
          report($sformatf("point (%0d, %0d, %0d) with nothing expected",
                           got.x, got.y, got.z));
        end else begin
          want = expected_points.pop_front();
          if (got.x != want.x) report($sformatf("out_x %0d, expected %0d", got.x, want.x));
          if (got.y != want.y) report($sformatf("out_y %0d, expected %0d", got.y, want.y));
          if (got.z != want.z) report($sformatf("out_z %0d, expected %0d", got.z, want.z));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_points.push_back(predict_point(s_tdata[IDX_W-1:0], s_tdata[2*IDX_W-1:IDX_W],
                                                s_tdata[2*IDX_W+HGT_W-1:2*IDX_W]));
      end
    end
    in_flight = expected_points.size();
  end

endmodule

// ----- test/scale_and_quaternion_rotate_point_test.sv -----
// Testbench top for the scale and quaternion rotate point block: drives register
// settings and points with random gaps and stalls, and gives the verdict.
// Depends on sqr_pkg, the block and scale_and_quaternion_rotate_point_checker.
module scale_and_quaternion_rotate_point_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sqr_pkg::*;

  localparam int ITEMS_PER_PHASE = 100;
  localparam int RANDOM_PHASES   = 20;
  localparam int CYCLE_LIMIT     = 1_000_000;

  typedef struct {
    quat_t              w;
    quat_t              x;
    quat_t              y;
    quat_t              z;
    logic [SCALE_W-1:0] zoom;
    logic [DIM_W-1:0]   cols;
    logic [DIM_W-1:0]   rows;
  } setting_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  int                   mismatches;
  int                   in_flight;
  int                   cycles = 0;
  int                   gap_style = 0;
  int                   stall_style = 0;
  int                   stall_left = 0;
  int                   results_seen = 0;
  logic                 result_moved = 1'b0;

  scale_and_quaternion_rotate_point dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  scale_and_quaternion_rotate_point_checker checker_inst (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("scale_and_quaternion_rotate_point_test: done, errors");
      $finish;
    end
  end

  function automatic int draw_wait(int style);
    case (style)
      0:       return 0;
      1:       return ($urandom_range(3) == 0) ? int'($urandom_range(16)) : 0;
      default: return int'($urandom_range(16));
    endcase
  endfunction

  function automatic int pick(int a, int b);
    return $urandom_range(1) ? a : b;
  endfunction

  function automatic setting_t make_setting(int w, int x, int y, int z, int zoom,
                                            int cols, int rows);
    setting_t st;
    st.w = quat_t'(w);
    st.x = quat_t'(x);
    st.y = quat_t'(y);
    st.z = quat_t'(z);
    st.zoom = SCALE_W'(zoom);
    st.cols = DIM_W'(cols);
    st.rows = DIM_W'(rows);
    return st;
  endfunction

  function automatic setting_t unit_rotation();
    real      a, b, c, d, n;
    setting_t st;
    a = $itor($urandom_range(2000)) - 1000.0;
    b = $itor($urandom_range(2000)) - 1000.0;
    c = $itor($urandom_range(2000)) - 1000.0;
    d = $itor($urandom_range(2000)) - 1000.0;
    n = $sqrt(a*a + b*b + c*c + d*d);
    if (n < 1.0) begin
      a = 1.0;
      n = 1.0;
    end
    st.w = quat_t'($rtoi(a / n * 16384.0));
    st.x = quat_t'($rtoi(b / n * 16384.0));
    st.y = quat_t'($rtoi(c / n * 16384.0));
    st.z = quat_t'($rtoi(d / n * 16384.0));
    return st;
  endfunction

  function automatic setting_t random_setting();
    setting_t st;
    int       dims [4] = '{0, 1, 1024, 2047};
    int       zooms [3] = '{0, 1, 65535};
    case ($urandom_range(3))
      0: begin
        st = unit_rotation();
        st.zoom = SCALE_W'($urandom_range(1023));
        st.cols = DIM_W'($urandom_range(1024, 1));
        st.rows = DIM_W'($urandom_range(1024, 1));
      end
      1: begin
        st.w = quat_t'(int'($urandom_range(32768)) - 16384);
        st.x = quat_t'(int'($urandom_range(32768)) - 16384);
        st.y = quat_t'(int'($urandom_range(32768)) - 16384);
        st.z = quat_t'(int'($urandom_range(32768)) - 16384);
        st.zoom = SCALE_W'($urandom_range(65535));
        st.cols = DIM_W'($urandom_range(2047));
        st.rows = DIM_W'($urandom_range(2047));
      end
      2: begin
        st = unit_rotation();
        st.zoom = 16'd256;
        st.cols = 11'd1024;
        st.rows = 11'd1024;
      end
      default: begin
        st.w = quat_t'((int'($urandom_range(2)) - 1) * 16384);
        st.x = quat_t'((int'($urandom_range(2)) - 1) * 16384);
        st.y = quat_t'((int'($urandom_range(2)) - 1) * 16384);
        st.z = quat_t'((int'($urandom_range(2)) - 1) * 16384);
        st.zoom = SCALE_W'(zooms[$urandom_range(2)]);
        st.cols = DIM_W'(dims[$urandom_range(3)]);
        st.rows = DIM_W'(dims[$urandom_range(3)]);
      end
    endcase
    return st;
  endfunction

  // Starts and ends at a falling edge.
  task automatic send_point(int c, int r, int h);
    int gap;
    gap = draw_wait(gap_style);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {HGT_W'(h), IDX_W'(r), IDX_W'(c)};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic apply_setting(setting_t st);
    logic [2:0]        regs [7];
    logic [DATA_W-1:0] vals [7];
    regs = '{REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z, REG_SCALE, REG_GRID_W,
             REG_GRID_H};
    vals = '{DATA_W'(st.w), DATA_W'(st.x), DATA_W'(st.y), DATA_W'(st.z),
             DATA_W'(st.zoom), DATA_W'(st.cols), DATA_W'(st.rows)};
    s_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    for (int i = 0; i < 7; i++) begin
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {regs[i], 2'b00};
      pwdata <= vals[i];
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      @(negedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // let the coefficient registers settle
    repeat (3) @(negedge clk);
  endtask

  always @(posedge clk) result_moved <= m_tvalid && m_tready;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (result_moved) begin
      results_seen++;
      if (results_seen % 50 == 0) stall_style = $urandom_range(2);
      stall_left = draw_wait(stall_style);
      m_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_point(0, 0, 0);
    send_point(1023, 1023, 2047);
    send_point(0, 0, -2048);
    send_point(512, 511, -1);
    // zero scale, non-unit quaternion, oversized and empty grid
    apply_setting(make_setting(16384, -16384, 16384, -16384, 0, 2047, 0));
    send_point(1023, 0, 2047);
    send_point(0, 1023, -2048);
    // full scale with squared norm four: saturate
    apply_setting(make_setting(-16384, 16384, 16384, 16384, 65535, 1024, 2047));
    send_point(1023, 1023, 2047);
    send_point(0, 0, -2048);
    send_point(1023, 0, -2048);
    send_point(0, 1023, 2047);
    // half-way values to test rounding ties
    apply_setting(make_setting(16384, 0, 0, 0, 128, 2, 2));
    send_point(0, 0, -1);
    send_point(1, 0, 1);
    send_point(0, 1, -3);
    // quarter turn about z
    apply_setting(make_setting(11585, 0, 0, 11585, 256, 1025, 1023));
    send_point(1023, 0, 100);
    send_point(0, 1023, -100);
    send_point(341, 682, -1365);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_setting(random_setting());
      gap_style = $urandom_range(2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(7) == 0) begin
          send_point(pick(0, 1023), pick(0, 1023), pick(-2048, 2047));
        end else begin
          send_point($urandom_range(1023), $urandom_range(1023),
                     int'($urandom_range(4095)) - 2048);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("scale_and_quaternion_rotate_point_test: done, clean");
    end else begin
      $display("scale_and_quaternion_rotate_point_test: done, errors");
    end
    $finish;
  end

endmodule
